FILE: design/cslmc_pkg.sv
// ----------------------------------------------------------------------------
// cslmc_pkg: shared types and constants for the chained LED matrix controller
// Transaction structs, event and result codes, select tables, bit reversal.
// ----------------------------------------------------------------------------
package cslmc_pkg;

    localparam int RING_BYTES = 32;
    localparam int WORD_BITS  = 16;
    localparam int RING_WORDS = RING_BYTES / 2;
    localparam int CELL_IDX_W = $clog2(RING_WORDS);
    localparam int BITS_W     = $clog2(WORD_BITS + 1);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);

    localparam logic [7:0]          IDLE_TIMEOUT_RESET = 8'd4;
    localparam logic [BITS_W-1:0]   BITS_FULL          = BITS_W'(WORD_BITS);

    // Input event codes
    localparam logic [1:0] OP_RISE = 2'd0;
    localparam logic [1:0] OP_FALL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_CHAIN = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic       chain_data_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       chain_clock_out;
        logic       chain_data_out;
        logic [7:0] select_low_group;
        logic [7:0] select_high_group;
        logic [7:0] lower_rows;
        logic [7:0] upper_rows;
    } out_item_t;

    // Active-low select for columns 0..7
    function automatic logic [7:0] sel_low(input logic [3:0] col);
        logic [7:0] r;
        case (col)
            4'd0:    r = 8'd127;
            4'd1:    r = 8'd191;
            4'd2:    r = 8'd223;
            4'd3:    r = 8'd239;
            4'd4:    r = 8'd247;
            4'd5:    r = 8'd251;
            4'd6:    r = 8'd253;
            4'd7:    r = 8'd254;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

    // Active-low select for columns 8..15
    function automatic logic [7:0] sel_high(input logic [3:0] col);
        logic [7:0] r;
        case (col)
            4'd8:    r = 8'd254;
            4'd9:    r = 8'd253;
            4'd10:   r = 8'd251;
            4'd11:   r = 8'd247;
            4'd12:   r = 8'd239;
            4'd13:   r = 8'd223;
            4'd14:   r = 8'd191;
            4'd15:   r = 8'd127;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] flip_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

FILE: design/cslmc_cell.sv
// ----------------------------------------------------------------------------
// cslmc_cell: one column word of the scrolling display ring
// Holds two display bytes; on scroll it takes the word of its neighbor.
// ----------------------------------------------------------------------------
module cslmc_cell (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  logic [15:0] neighbor_word,
    output logic [15:0] word
);
    import cslmc_pkg::*;

    logic [15:0] word_reg;
    logic [15:0] word_next;

    // Take the neighbor's word on scroll, else hold
    always_comb
    begin
        word_next = shift ? neighbor_word : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

FILE: design/chained_scrolling_led_matrix_controller_top.sv
// ----------------------------------------------------------------------------
// chained_scrolling_led_matrix_controller_top: cascadable LED matrix controller
// Serial chain shifter, scrolling column ring and column refresh scanner.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one pin event per transaction: a rising
//   or falling chain clock edge, a refresh tick, or no event. Every input
//   transaction yields exactly one output transaction on out_valid/out_stall/
//   out_data: a chain pin update, a driver frame, or nothing to drive.
//   The display store is a ring of 16 word cells kept in start order; a
//   completed 16-bit word scrolls the whole ring by one cell, all cells at once.
//   Each accepted transaction's result is registered into the output stage;
//   the block accepts one transaction per cycle while in_stall is low.
//   A two-entry output stage (result register plus skid register) lets the
//   block keep accepting while one result waits; in_stall rises only when
//   both entries are full and falls as soon as out_stall releases.
//   cfg_write/cfg_data load the idle timeout (refresh ticks without a falling
//   edge before a partial word is dropped); the user must write it while
//   the block is idle, which it does not enforce. Reset clears the ring, the
//   shifter and scanner, loads a timeout of 4 and empties the output stage.
// ----------------------------------------------------------------------------
module chained_scrolling_led_matrix_controller_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cslmc_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cslmc_pkg::out_item_t  out_data,
    input  logic                  cfg_write,
    input  logic [7:0]            cfg_data
);
    import cslmc_pkg::*;

    // Control state
    logic [15:0]       word_in_reg,    word_in_next;
    logic [BITS_W-1:0] bits_left_reg,  bits_left_next;
    logic [15:0]       word_out_reg,   word_out_next;
    logic              clk_level_reg,  clk_level_next;
    logic              data_level_reg, data_level_next;
    logic [3:0]        scan_col_reg,   scan_col_next;
    logic              blank_reg,      blank_next;
    logic [15:0]       idle_reg,       idle_next;
    logic [7:0]        timeout_reg;

    // Output stage
    logic              ov_reg;
    out_item_t         op_reg;
    logic              sv_reg;
    out_item_t         sp_reg;

    logic              in_fire;
    logic              out_free;
    logic              scroll;
    out_item_t         result;
    logic [15:0]       cell_word [RING_WORDS];
    logic [15:0]       word_set;
    logic [BITS_W-1:0] bits_dec;
    logic [3:0]        scan_col_inc;
    logic [15:0]       col_word;

    assign in_fire  = in_valid && !sv_reg;
    assign out_free = !ov_reg || !out_stall;

    // Ring of word cells; cell k holds the word at start + k
    genvar k;
    generate
        for (k = 0; k < RING_WORDS; k++)
        begin : g_cell
            logic [15:0] nb;
            if (k == RING_WORDS - 1)
            begin : g_tail
                assign nb = word_set;
            end
            else
            begin : g_body
                assign nb = cell_word[k+1];
            end
            cslmc_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .shift         (scroll),
                .neighbor_word (nb),
                .word          (cell_word[k])
            );
        end
    endgenerate

    // Column that a real frame shows next
    assign scan_col_inc = scan_col_reg + 4'd1;
    assign col_word     = cell_word[scan_col_inc[CELL_IDX_W-1:0]];

    // Event decode and next state
    always_comb
    begin
        word_in_next    = word_in_reg;
        bits_left_next  = bits_left_reg;
        word_out_next   = word_out_reg;
        clk_level_next  = clk_level_reg;
        data_level_next = data_level_reg;
        scan_col_next   = scan_col_reg;
        blank_next      = blank_reg;
        idle_next       = idle_reg;
        scroll          = 1'b0;
        result          = '0;
        bits_dec        = bits_left_reg - BITS_W'(1);
        word_set        = word_in_reg;
        word_set[bits_dec[BIT_IDX_W-1:0]] = word_in_reg[bits_dec[BIT_IDX_W-1:0]]
                                          | in_data.chain_data_in;

        case (in_data.opcode)
            OP_RISE:
            begin
                clk_level_next  = 1'b0;
                data_level_next = word_out_reg[bits_dec[BIT_IDX_W-1:0]];
                if (bits_dec == '0)
                begin
                    // Word complete: pass on the next word and scroll
                    word_out_next  = cell_word[1];
                    scroll         = in_fire;
                    word_in_next   = '0;
                    bits_left_next = BITS_FULL;
                end
                else
                begin
                    word_in_next   = word_set;
                    bits_left_next = bits_dec;
                end
                result.kind            = KIND_CHAIN;
                result.chain_clock_out = 1'b0;
                result.chain_data_out  = data_level_next;
            end
            OP_FALL:
            begin
                clk_level_next         = 1'b1;
                idle_next              = '0;
                result.kind            = KIND_CHAIN;
                result.chain_clock_out = 1'b1;
                result.chain_data_out  = data_level_reg;
            end
            OP_TICK:
            begin
                result.kind = KIND_FRAME;
                if (blank_reg)
                begin
                    blank_next = 1'b0;
                end
                else
                begin
                    blank_next        = 1'b1;
                    scan_col_next     = scan_col_inc;
                    result.upper_rows = col_word[15:8];
                    result.lower_rows = flip_byte(col_word[7:0]);
                end
                result.select_low_group  = sel_low(scan_col_next);
                result.select_high_group = sel_high(scan_col_next);
                idle_next = idle_reg + 16'd1;
                // Drop a partial word on idle timeout
                if (idle_next == {8'd0, timeout_reg})
                begin
                    word_in_next   = '0;
                    bits_left_next = BITS_FULL;
                end
            end
            OP_NONE:
            begin
                result.kind = KIND_NONE;
            end
            default:
            begin
                result.kind = KIND_NONE;
            end
        endcase
    end

    // Hold state; advance on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_in_reg    <= '0;
            bits_left_reg  <= BITS_FULL;
            word_out_reg   <= '0;
            clk_level_reg  <= 1'b0;
            data_level_reg <= 1'b0;
            scan_col_reg   <= '0;
            blank_reg      <= 1'b0;
            idle_reg       <= '0;
            timeout_reg    <= IDLE_TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                timeout_reg <= cfg_data;
            end
            if (in_fire)
            begin
                word_in_reg    <= word_in_next;
                bits_left_reg  <= bits_left_next;
                word_out_reg   <= word_out_next;
                clk_level_reg  <= clk_level_next;
                data_level_reg <= data_level_next;
                scan_col_reg   <= scan_col_next;
                blank_reg      <= blank_next;
                idle_reg       <= idle_next;
            end
        end
    end

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (sv_reg)
            begin
                ov_reg <= 1'b1;
                sv_reg <= 1'b0;
            end
            else
            begin
                ov_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            sv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (sv_reg)
            begin
                op_reg <= sp_reg;
            end
            else if (in_fire)
            begin
                op_reg <= result;
            end
        end
        else if (in_fire)
        begin
            sp_reg <= result;
        end
    end

    assign in_stall  = sv_reg;
    assign out_valid = ov_reg;
    assign out_data  = op_reg;

endmodule

FILE: tb/cslmc_checker.sv
// ----------------------------------------------------------------------------
// cslmc_checker: result checker for the chained LED matrix controller
// Watches the event, result and timeout-register ports, keeps its own copy of
// the shifter, scrolling ring and column scanner, predicts one result per
// accepted event and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module cslmc_checker
    import cslmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_item_t   in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_item_t  out_data,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    output int         errors,
    output int         pending
);

    localparam int RING_AW = $clog2(RING_BYTES);

    out_item_t           due_results[$];
    logic [7:0]          ring [RING_BYTES];
    logic [RING_AW-1:0]  start;
    logic [15:0]         word_in;
    logic [15:0]         word_out;
    logic [BITS_W-1:0]   bits_left;
    logic                clk_level;
    logic                data_level;
    logic [3:0]          column;
    logic                blank;
    logic [15:0]         idle_ticks;
    logic [7:0]          timeout;

    initial errors = 0;
    initial pending = 0;

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        $display("MISMATCH %s: got 0x%02h expected 0x%02h at %0t", field, got, want, $time);
        errors++;
    endtask

    // Return the matrix to its power-up contents
    task automatic clear_matrix();
        for (int i = 0; i < RING_BYTES; i++)
        begin
            ring[i] = 8'h00;
        end
        start      = '0;
        word_in    = '0;
        word_out   = '0;
        bits_left  = BITS_FULL;
        clk_level  = 1'b0;
        data_level = 1'b0;
        column     = '0;
        blank      = 1'b0;
        idle_ticks = '0;
        timeout    = IDLE_TIMEOUT_RESET;
    endtask

    // Apply one pin event to the matrix copy and return the pin or frame it drives
    function automatic out_item_t advance_matrix(input in_item_t ev);
        out_item_t           r;
        logic [RING_AW-1:0]  a;
        logic [7:0]          hi_byte;
        logic [7:0]          lo_byte;
        r = '0;
        hi_byte = 8'h00;
        lo_byte = 8'h00;
        case (ev.opcode)
            OP_RISE:
            begin
                // shift one bit in, MSB first, and pass the matching old bit on
                bits_left = bits_left - 1'b1;
                if (ev.chain_data_in)
                    word_in[bits_left] = 1'b1;
                clk_level  = 1'b0;
                data_level = word_out[bits_left];
                if (bits_left == 0)
                begin
                    // store the full word and scroll one column
                    word_out = {ring[start + RING_AW'(2)], ring[start + RING_AW'(3)]};
                    ring[start]                = word_in[15:8];
                    ring[start + RING_AW'(1)]  = word_in[7:0];
                    start     = start + RING_AW'(2);
                    word_in   = '0;
                    bits_left = BITS_FULL;
                end
                r.kind            = KIND_CHAIN;
                r.chain_clock_out = clk_level;
                r.chain_data_out  = data_level;
            end
            OP_FALL:
            begin
                clk_level  = 1'b1;
                idle_ticks = '0;
                r.kind            = KIND_CHAIN;
                r.chain_clock_out = clk_level;
                r.chain_data_out  = data_level;
            end
            OP_TICK:
            begin
                // alternate blank and real columns
                if (blank)
                begin
                    blank = 1'b0;
                end
                else
                begin
                    blank   = 1'b1;
                    column  = column + 1'b1;
                    a       = start + {column, 1'b0};
                    hi_byte = ring[a];
                    lo_byte = ring[a + RING_AW'(1)];
                end
                r.kind              = KIND_FRAME;
                r.select_low_group  = (column < 8) ? ~(8'h80 >> column[2:0]) : 8'hFF;
                r.select_high_group = (column >= 8) ? ~(8'h01 << column[2:0]) : 8'hFF;
                for (int i = 0; i < 8; i++)
                begin
                    r.lower_rows[i] = lo_byte[7-i];
                end
                r.upper_rows = hi_byte;
                // drop a partial word once the line has been quiet long enough
                idle_ticks = idle_ticks + 1'b1;
                if (idle_ticks == {8'h00, timeout})
                begin
                    word_in   = '0;
                    bits_left = BITS_FULL;
                end
            end
            default:
            begin
                r.kind = KIND_NONE;
            end
        endcase
        return r;
    endfunction

    // Compare results first: a result never belongs to an event of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_matrix();
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    report("unexpected result kind", 8'(out_data.kind), 8'h00);
                end
                else
                begin
                    out_item_t want;
                    want = due_results.pop_front();
                    if (out_data.kind !== want.kind)
                        report("kind", 8'(out_data.kind), 8'(want.kind));
                    if (out_data.chain_clock_out !== want.chain_clock_out)
                        report("chain_clock_out", 8'(out_data.chain_clock_out),
                               8'(want.chain_clock_out));
                    if (out_data.chain_data_out !== want.chain_data_out)
                        report("chain_data_out", 8'(out_data.chain_data_out),
                               8'(want.chain_data_out));
                    if (out_data.select_low_group !== want.select_low_group)
                        report("select_low_group", out_data.select_low_group,
                               want.select_low_group);
                    if (out_data.select_high_group !== want.select_high_group)
                        report("select_high_group", out_data.select_high_group,
                               want.select_high_group);
                    if (out_data.lower_rows !== want.lower_rows)
                        report("lower_rows", out_data.lower_rows, want.lower_rows);
                    if (out_data.upper_rows !== want.upper_rows)
                        report("upper_rows", out_data.upper_rows, want.upper_rows);
                end
            end
            if (cfg_write)
                timeout = cfg_data;
            if (in_valid && !in_stall)
                due_results.push_back(advance_matrix(in_data));
            pending <= due_results.size();
        end
    end

endmodule

FILE: tb/chained_scrolling_led_matrix_controller_top_tb.sv
// ----------------------------------------------------------------------------
// chained_scrolling_led_matrix_controller_top_tb: testbench top
// Resets the controller, drives directed and random pin events with random
// gaps and output stalls, rewrites the idle timeout between phases, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module chained_scrolling_led_matrix_controller_top_tb;
    import cslmc_pkg::*;

    localparam int RANDOM_EVENTS = 640;
    localparam int PHASES        = 8;
    localparam int QUIET_LIMIT   = 2000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_write;
    logic [7:0] cfg_data;
    int         errors;
    int         pending;
    int         sent;
    int         stall_left;
    int         quiet_cycles;
    logic       steady;

    chained_scrolling_led_matrix_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    cslmc_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle cycles before the next transaction on either side
    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 17);
    endfunction

    // Hold out_stall for a random count after each accepted result
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            stall_left <= draw_wait();
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("chained_scrolling_led_matrix_controller_top verification failed");
            $finish;
        end
    end

    // Present one pin event after a random gap and hold it until accepted
    task automatic send(input logic [1:0] op, input logic din);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= in_item_t'{op, din};
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic set_timeout(input logic [7:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_rises(input int count);
        for (int i = 0; i < count; i++)
        begin
            send(OP_RISE, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
        begin
            send(OP_TICK, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [15:0] pattern;
        int          target;
        int          pick;
        int          n;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        cfg_write    = 1'b0;
        cfg_data     = '0;
        stall_left   = 0;
        quiet_cycles = 0;
        sent         = 0;
        steady       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle events, blank and real columns, one full word, timeout
        send(OP_NONE, 1'b0);
        send(OP_NONE, 1'b1);
        send(OP_TICK, 1'b0);
        send(OP_TICK, 1'b1);
        send(OP_FALL, 1'b1);
        pattern = 16'hA5C3;
        for (int i = 15; i >= 0; i--)
        begin
            send(OP_RISE, pattern[i]);
        end
        send(OP_TICK, 1'b0);
        send(OP_TICK, 1'b0);
        send(OP_FALL, 1'b0);
        send_rises(3);
        send_ticks(4);

        // Extreme timeouts: longest, and zero which holds partial words
        set_timeout(8'd255);
        steady = 1'b1;
        send(OP_FALL, 1'b0);
        send_rises(7);
        send_ticks(256);
        send_rises(9);
        send_ticks(4);
        set_timeout(8'd0);
        send(OP_FALL, 1'b1);
        send_rises(5);
        send_ticks(20);
        send_rises(11);
        send(OP_FALL, 1'b0);
        send_rises(16);
        send_ticks(6);
        steady = 1'b0;

        // Random phases, each with its own timeout and idling style
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                set_timeout(8'd1);
            else if (p == 1)
                set_timeout(8'd255);
            else if (p == 2)
                set_timeout(8'd2);
            else
                set_timeout(8'($urandom_range(1, 32)));
            steady = (p % 3 == 2);
            target = sent + RANDOM_EVENTS / PHASES;
            while (sent < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    // clock pulses with data, refresh now and then
                    n = $urandom_range(1, 20);
                    for (int k = 0; k < n; k++)
                    begin
                        send(OP_RISE, 1'($urandom_range(0, 1)));
                        send(OP_FALL, 1'($urandom_range(0, 1)));
                        if ($urandom_range(0, 3) == 0)
                            send(OP_TICK, 1'($urandom_range(0, 1)));
                    end
                end
                else if (pick < 9)
                begin
                    send_ticks($urandom_range(1, 10));
                end
                else
                begin
                    // noise: any event code, broken pulses
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                    begin
                        send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                    end
                end
            end
        end

        set_timeout(8'd4);
        send_rises(16);
        send_ticks(8);

        drain();
        repeat (8) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("chained_scrolling_led_matrix_controller_top verification clean");
        else
            $display("chained_scrolling_led_matrix_controller_top verification failed");
        $finish;
    end

endmodule

FILE: sim.f
design/cslmc_pkg.sv
design/cslmc_cell.sv
design/chained_scrolling_led_matrix_controller_top.sv
tb/cslmc_checker.sv
tb/chained_scrolling_led_matrix_controller_top_tb.sv
